>>> rtl/tpi_pkg.sv
// Package for the three-plane intersection solver.
// Holds field widths, pipeline widths and the divider flag type.
// No dependencies.
package tpi_pkg;

  // Default number of fraction bits of every fixed-point value.
  localparam int FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int IN_W    = 32;
  localparam int LIMIT_W = 31;
  localparam int Q_W     = 32;

  // Exact intermediate widths: product, 2x2 minor, minor times scalar, 3-term sum.
  localparam int PROD_W  = 2 * IN_W;
  localparam int MINOR_W = PROD_W + 1;
  localparam int PART_W  = IN_W + 33;
  localparam int TERM_W  = MINOR_W + IN_W;
  localparam int SUM_W   = TERM_W + 2;

  // Front stages before the divider.
  localparam int FRONT_STAGES = 6;

  // Divider output flags: quotient too large for 32 bits, result negative.
  typedef struct packed {
    logic ovf;
    logic neg;
  } tpi_div_flags_t;

endpackage

>>> rtl/tpi_in_if.sv
// Input channel: three plane equations per word.
// Depends on tpi_pkg.
interface tpi_in_if;
  import tpi_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [IN_W-1:0] first_normal_x;
  logic signed [IN_W-1:0] first_normal_y;
  logic signed [IN_W-1:0] first_normal_z;
  logic signed [IN_W-1:0] first_dist;
  logic signed [IN_W-1:0] second_normal_x;
  logic signed [IN_W-1:0] second_normal_y;
  logic signed [IN_W-1:0] second_normal_z;
  logic signed [IN_W-1:0] second_dist;
  logic signed [IN_W-1:0] third_normal_x;
  logic signed [IN_W-1:0] third_normal_y;
  logic signed [IN_W-1:0] third_normal_z;
  logic signed [IN_W-1:0] third_dist;

  modport source (
    output valid, first_normal_x, first_normal_y, first_normal_z, first_dist,
           second_normal_x, second_normal_y, second_normal_z, second_dist,
           third_normal_x, third_normal_y, third_normal_z, third_dist,
    input  ready
  );
  modport sink (
    input  valid, first_normal_x, first_normal_y, first_normal_z, first_dist,
           second_normal_x, second_normal_y, second_normal_z, second_dist,
           third_normal_x, third_normal_y, third_normal_z, third_dist,
    output ready
  );
endinterface

>>> rtl/tpi_out_if.sv
// Result channel: intersection point and found flag per word.
// Depends on tpi_pkg.
interface tpi_out_if;
  import tpi_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [Q_W-1:0]  point_x;
  logic signed [Q_W-1:0]  point_y;
  logic signed [Q_W-1:0]  point_z;
  logic                   point_found;

  modport source (output valid, point_x, point_y, point_z, point_found, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_found, output ready);
endinterface

>>> rtl/tpi_cfg_if.sv
// Configuration write channel carrying the parallel limit.
// Depends on tpi_pkg.
interface tpi_cfg_if;
  import tpi_pkg::*;

  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] parallel_limit;

  modport source (output valid, parallel_limit, input ready);
  modport sink   (input valid, parallel_limit, output ready);
endinterface

>>> rtl/tpi_div.sv
// Pipelined restoring divider: 32-bit quotient of magnitudes plus overflow flag.
// One quotient bit per stage. Depends on tpi_pkg.
module tpi_div #(
  parameter int WD = 99,
  parameter int WN = 115
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [WN-1:0]            num_mag,
  input  logic [WD-1:0]            den_mag,
  input  logic                     neg_in,
  output logic [tpi_pkg::Q_W-1:0]  quo,
  output tpi_pkg::tpi_div_flags_t  flags
);
  import tpi_pkg::*;

  localparam int WR = WD + Q_W;

  logic [WR-1:0]  rem_r [Q_W];
  logic [WD-1:0]  den_r [Q_W];
  logic [Q_W-1:0] q_r   [Q_W+1];
  tpi_div_flags_t fl_r  [Q_W+1];

  // Entry stage: a quotient of 2^32 or more is flagged and saturates later.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]     <= WR'(num_mag);
      den_r[0]     <= den_mag;
      q_r[0]       <= '0;
      fl_r[0].ovf  <= WR'(num_mag) >= (WR'(den_mag) << Q_W);
      fl_r[0].neg  <= neg_in;
    end
  end

  // One compare and subtract per stage, most significant quotient bit first.
  for (genvar i = 0; i < Q_W; i++) begin : g_bit
    localparam int K = Q_W - 1 - i;
    logic [WR-1:0] dsh;
    logic          ge;

    always_comb begin
      dsh = WR'(den_r[i]) << K;
      ge  = rem_r[i] >= dsh;
    end

    // Bit K of the incoming quotient is still clear, so it is simply ORed in.
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1]  <= q_r[i] | (Q_W'(ge) << K);
        fl_r[i+1] <= fl_r[i];
      end
    end

    if (i < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= ge ? rem_r[i] - dsh : rem_r[i];
          den_r[i+1] <= den_r[i];
        end
      end
    end
  end

  assign quo   = q_r[Q_W];
  assign flags = fl_r[Q_W];

endmodule

>>> rtl/three_plane_intersection.sv
// Top level of the three-plane intersection solver (Cramer's rule, fixed point).
// Depends on tpi_pkg, tpi_in_if, tpi_out_if, tpi_cfg_if and tpi_div.
//
//   channel   | direction | contents
//   in_chan   | sink      | three planes: normal x, y, z and distance each
//   out_chan  | source    | point x, y, z and point_found
//   cfg_chan  | sink      | parallel_limit, always ready
//
// One word is accepted every cycle unless the output is stalled.
// Six front stages form products, minors, partial products, terms, sums and
// magnitudes, then 33 divider stages (an entry stage and one per quotient bit),
// then the output register.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears the valid bits and loads parallel_limit with one.
module three_plane_intersection #(
  parameter int FRAC_BITS = tpi_pkg::FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  tpi_in_if.sink   in_chan,
  tpi_out_if.source out_chan,
  tpi_cfg_if.sink  cfg_chan
);
  import tpi_pkg::*;

  localparam int WN      = SUM_W + FRAC_BITS;
  localparam int DIV_LAT = Q_W + 1;
  localparam int NVLD    = FRONT_STAGES + DIV_LAT;

  logic                adv;
  logic [NVLD-1:0]     vld_r;
  logic                out_valid_r;
  logic [LIMIT_W-1:0]  limit_r;

  // Stage registers.
  logic signed [PROD_W-1:0]  prod_r  [12];
  logic signed [IN_W-1:0]    sc1_r   [4];
  logic signed [MINOR_W-1:0] minor_r [6];
  logic signed [IN_W-1:0]    sc2_r   [4];
  logic signed [PART_W-1:0]  plo_r   [12];
  logic signed [PART_W-1:0]  phi_r   [12];
  logic signed [TERM_W-1:0]  term_r  [12];
  logic signed [SUM_W-1:0]   det_r;
  logic signed [SUM_W-1:0]   num_r   [3];
  logic [SUM_W-1:0]          dmag_r;
  logic [WN-1:0]             nmag_r  [3];
  logic                      neg_r   [3];
  logic                      found_r;
  logic                      fpipe_r [DIV_LAT];

  logic signed [Q_W-1:0] px_r, py_r, pz_r;
  logic                  pf_r;

  // Minor and scalar index lists for the twelve minor-by-scalar terms.
  // Minors: 0 bc, 1 ac, 2 ab, 3 dc, 4 db, 5 ad. Scalars: 0 n1x, 1 n1y, 2 n1z, 3 d1.
  localparam int TM [12] = '{0, 1, 2, 3, 0, 4, 1, 3, 5, 5, 4, 2};
  localparam int TS [12] = '{0, 1, 2, 1, 3, 2, 3, 0, 2, 1, 0, 3};

  // Global advance: the pipeline moves whenever the output can take a word.
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;
  assign cfg_chan.ready = 1'b1;

  // Control: limit register and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_W'(1);
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        limit_r <= cfg_chan.parallel_limit;
      end
      if (adv) begin
        vld_r       <= {vld_r[NVLD-2:0], in_chan.valid};
        out_valid_r <= vld_r[NVLD-1];
      end
    end
  end

  // Stage 1: the twelve 32x32 products of the minors.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r[0]  <= in_chan.second_normal_y * in_chan.third_normal_z;
      prod_r[1]  <= in_chan.third_normal_y  * in_chan.second_normal_z;
      prod_r[2]  <= in_chan.second_normal_x * in_chan.third_normal_z;
      prod_r[3]  <= in_chan.third_normal_x  * in_chan.second_normal_z;
      prod_r[4]  <= in_chan.second_normal_x * in_chan.third_normal_y;
      prod_r[5]  <= in_chan.third_normal_x  * in_chan.second_normal_y;
      prod_r[6]  <= in_chan.second_dist     * in_chan.third_normal_z;
      prod_r[7]  <= in_chan.third_dist      * in_chan.second_normal_z;
      prod_r[8]  <= in_chan.second_dist     * in_chan.third_normal_y;
      prod_r[9]  <= in_chan.third_dist      * in_chan.second_normal_y;
      prod_r[10] <= in_chan.third_dist      * in_chan.second_normal_x;
      prod_r[11] <= in_chan.second_dist     * in_chan.third_normal_x;
      sc1_r[0]   <= in_chan.first_normal_x;
      sc1_r[1]   <= in_chan.first_normal_y;
      sc1_r[2]   <= in_chan.first_normal_z;
      sc1_r[3]   <= in_chan.first_dist;
    end
  end

  // Stage 2: exact 2x2 minors.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int m = 0; m < 6; m++) begin
        minor_r[m] <= MINOR_W'(prod_r[2*m]) - MINOR_W'(prod_r[2*m+1]);
      end
      sc2_r <= sc1_r;
    end
  end

  // Stage 3: each minor times its scalar, split into low and high partial products.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 12; t++) begin
        plo_r[t] <= $signed({1'b0, minor_r[TM[t]][31:0]}) * sc2_r[TS[t]];
        phi_r[t] <= $signed(minor_r[TM[t]][MINOR_W-1:32]) * sc2_r[TS[t]];
      end
    end
  end

  // Stage 4: recombine the partial products into exact terms.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 12; t++) begin
        term_r[t] <= (TERM_W'(phi_r[t]) <<< 32) + TERM_W'(plo_r[t]);
      end
    end
  end

  // Stage 5: determinant and the three Cramer numerators.
  always_ff @(posedge clk) begin
    if (adv) begin
      det_r    <= SUM_W'(term_r[0]) - SUM_W'(term_r[1]) + SUM_W'(term_r[2]);
      num_r[0] <= SUM_W'(term_r[3]) - SUM_W'(term_r[4]) - SUM_W'(term_r[5]);
      num_r[1] <= SUM_W'(term_r[6]) - SUM_W'(term_r[7]) - SUM_W'(term_r[8]);
      num_r[2] <= SUM_W'(term_r[9]) + SUM_W'(term_r[10]) - SUM_W'(term_r[11]);
    end
  end

  // Stage 6: magnitudes, signs and the parallel test against the scaled limit.
  logic [SUM_W-1:0] dmag;
  logic [SUM_W-1:0] lim;
  logic [SUM_W-1:0] nmag [3];

  always_comb begin
    dmag = det_r[SUM_W-1] ? SUM_W'(-det_r) : SUM_W'(det_r);
    lim  = SUM_W'(limit_r) << (2 * FRAC_BITS);
    for (int c = 0; c < 3; c++) begin
      nmag[c] = num_r[c][SUM_W-1] ? SUM_W'(-num_r[c]) : SUM_W'(num_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag_r  <= dmag;
      found_r <= (det_r != '0) && !(dmag < lim);
      for (int c = 0; c < 3; c++) begin
        nmag_r[c] <= WN'(nmag[c]) << FRAC_BITS;
        neg_r[c]  <= num_r[c][SUM_W-1] ^ det_r[SUM_W-1];
      end
    end
  end

  // Found flag travels alongside the divider stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      fpipe_r[0] <= found_r;
      for (int s = 1; s < DIV_LAT; s++) begin
        fpipe_r[s] <= fpipe_r[s-1];
      end
    end
  end

  // Three dividers, one per coordinate.
  logic [Q_W-1:0]  quo [3];
  tpi_div_flags_t  dfl [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    tpi_div #(
      .WD (SUM_W),
      .WN (WN)
    ) u_div (
      .clk     (clk),
      .en      (adv),
      .num_mag (nmag_r[c]),
      .den_mag (dmag_r),
      .neg_in  (neg_r[c]),
      .quo     (quo[c]),
      .flags   (dfl[c])
    );
  end

  // Sign and saturation of each coordinate; zero when parallel.
  logic [Q_W-1:0] coord [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!fpipe_r[DIV_LAT-1]) begin
        coord[c] = '0;
      end else if (dfl[c].neg) begin
        if (dfl[c].ovf || quo[c] > {1'b1, {(Q_W-1){1'b0}}}) begin
          coord[c] = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
          coord[c] = -quo[c];
        end
      end else begin
        if (dfl[c].ovf || quo[c][Q_W-1]) begin
          coord[c] = {1'b0, {(Q_W-1){1'b1}}};
        end else begin
          coord[c] = quo[c];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= $signed(coord[0]);
      py_r <= $signed(coord[1]);
      pz_r <= $signed(coord[2]);
      pf_r <= fpipe_r[DIV_LAT-1];
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.point_x     = px_r;
  assign out_chan.point_y     = py_r;
  assign out_chan.point_z     = pz_r;
  assign out_chan.point_found = pf_r;

endmodule

>>> tb/sv/three_plane_intersection_chk.sv
// Checker for the three-plane intersection solver: watches the three channels,
// predicts each point by exact Cramer's rule and compares every result word.
// Depends on tpi_pkg, tpi_in_if, tpi_out_if and tpi_cfg_if.
module three_plane_intersection_chk (
  input  logic clk,
  input  logic rst_n,
  tpi_in_if    in_chan,
  tpi_out_if   out_chan,
  tpi_cfg_if   cfg_chan,
  output int   error_count,
  output int   pending,
  output int   found_count,
  output int   parallel_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpi_pkg::*;

  // Wide enough for every exact intermediate, including the shifted numerator.
  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
    logic                  found;
  } point_t;

  point_t             point_q[$];
  logic [LIMIT_W-1:0] limit_reg;

  // a*b - c*d, exact.
  function automatic wide_t cross2(input logic signed [IN_W-1:0] a, b, c, d);
    cross2 = wide_t'(a) * wide_t'(b) - wide_t'(c) * wide_t'(d);
  endfunction

  // Quotient of numerator and determinant, truncated toward zero and saturated.
  function automatic logic signed [Q_W-1:0] coord_of(input wide_t num, input wide_t det);
    logic         neg;
    logic [159:0] mag_n;
    logic [159:0] mag_d;
    logic [159:0] quo;
    neg   = (num < 0) != (det < 0);
    mag_n = (num < 0) ? -num : num;
    mag_d = (det < 0) ? -det : det;
    quo   = (mag_n << FRAC_BITS_DEF) / mag_d;
    if (neg) begin
      if (quo > 160'h8000_0000) coord_of = 32'sh8000_0000;
      else coord_of = -quo[31:0];
    end else begin
      if (quo > 160'h7FFF_FFFF) coord_of = 32'sh7FFF_FFFF;
      else coord_of = quo[31:0];
    end
  endfunction

  // Expected point for the word now on the input channel.
  function automatic point_t solve_planes(input logic [LIMIT_W-1:0] lim);
    point_t                p;
    wide_t                 bc, ac, ab, det, dc, db, ad, lim_w, mag;
    logic signed [IN_W-1:0] n1x, n1y, n1z, d1, n2x, n2y, n2z, d2, n3x, n3y, n3z, d3;
    n1x = in_chan.first_normal_x;  n1y = in_chan.first_normal_y;
    n1z = in_chan.first_normal_z;  d1  = in_chan.first_dist;
    n2x = in_chan.second_normal_x; n2y = in_chan.second_normal_y;
    n2z = in_chan.second_normal_z; d2  = in_chan.second_dist;
    n3x = in_chan.third_normal_x;  n3y = in_chan.third_normal_y;
    n3z = in_chan.third_normal_z;  d3  = in_chan.third_dist;
    bc  = cross2(n2y, n3z, n3y, n2z);
    ac  = cross2(n2x, n3z, n3x, n2z);
    ab  = cross2(n2x, n3y, n3x, n2y);
    det = bc * wide_t'(n1x) - ac * wide_t'(n1y) + ab * wide_t'(n1z);
    // The limit has single fraction bits, the determinant three times as many.
    lim_w = wide_t'({1'b0, lim}) <<< (2 * FRAC_BITS_DEF);
    mag   = (det < 0) ? -det : det;
    p = '{x: '0, y: '0, z: '0, found: 1'b0};
    if (det != 0 && mag >= lim_w) begin
      dc = cross2(d2, n3z, d3, n2z);
      db = cross2(d2, n3y, d3, n2y);
      ad = cross2(d3, n2x, d2, n3x);
      p.x = coord_of(dc * wide_t'(n1y) - bc * wide_t'(d1) - db * wide_t'(n1z), det);
      p.y = coord_of(ac * wide_t'(d1) - dc * wide_t'(n1x) - ad * wide_t'(n1z), det);
      p.z = coord_of(ad * wide_t'(n1y) + db * wide_t'(n1x) - ab * wide_t'(d1), det);
      p.found = 1'b1;
    end
    return p;
  endfunction

  initial begin
    error_count    = 0;
    pending        = 0;
    found_count    = 0;
    parallel_count = 0;
  end

  // Track the register, queue predictions and compare result words in order.
  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      limit_reg = 1;
    end else begin
      if (in_chan.valid && in_chan.ready) point_q.push_back(solve_planes(limit_reg));
      if (cfg_chan.valid && cfg_chan.ready) limit_reg = cfg_chan.parallel_limit;
      if (out_chan.valid && out_chan.ready) begin
        if (point_q.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          error_count++;
        end else begin
          want = point_q.pop_front();
          if (want.found) found_count++;
          else parallel_count++;
          if (out_chan.point_x !== want.x) begin
            $display("%0t: point_x expected %h got %h", $time, want.x, out_chan.point_x);
            error_count++;
          end
          if (out_chan.point_y !== want.y) begin
            $display("%0t: point_y expected %h got %h", $time, want.y, out_chan.point_y);
            error_count++;
          end
          if (out_chan.point_z !== want.z) begin
            $display("%0t: point_z expected %h got %h", $time, want.z, out_chan.point_z);
            error_count++;
          end
          if (out_chan.point_found !== want.found) begin
            $display("%0t: point_found expected %b got %b", $time, want.found,
                     out_chan.point_found);
            error_count++;
          end
        end
      end
    end
    pending = point_q.size();
  end
endmodule

>>> tb/sv/three_plane_intersection_tb.sv
// Top of the three-plane intersection testbench: clock, reset, stimulus and verdict.
// Depends on tpi_pkg, the channel interfaces, the solver and three_plane_intersection_chk.
module three_plane_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpi_pkg::*;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam int                 IDLE_LIMIT = 3000;
  localparam int                 PHASE_WORDS = 110;

  typedef logic signed [31:0] plane_set_t [12];

  logic clk;
  logic rst_n;
  int   error_count, pending, found_count, parallel_count;
  int   idle_cycles;
  bit   burst;

  tpi_in_if  in_chan ();
  tpi_out_if out_chan ();
  tpi_cfg_if cfg_chan ();

  three_plane_intersection i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  three_plane_intersection_chk i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .out_chan       (out_chan),
    .cfg_chan       (cfg_chan),
    .error_count    (error_count),
    .pending        (pending),
    .found_count    (found_count),
    .parallel_count (parallel_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_planes(input plane_set_t p);
    bit rdy;
    int g;
    in_chan.valid           <= 1'b1;
    in_chan.first_normal_x  <= p[0];
    in_chan.first_normal_y  <= p[1];
    in_chan.first_normal_z  <= p[2];
    in_chan.first_dist      <= p[3];
    in_chan.second_normal_x <= p[4];
    in_chan.second_normal_y <= p[5];
    in_chan.second_normal_z <= p[6];
    in_chan.second_dist     <= p[7];
    in_chan.third_normal_x  <= p[8];
    in_chan.third_normal_y  <= p[9];
    in_chan.third_normal_z  <= p[10];
    in_chan.third_dist      <= p[11];
    do begin
      @(negedge clk);
      rdy = in_chan.ready;
      @(posedge clk);
    end while (!rdy);
    g = gap_len();
    if (g > 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stops offering words, waits until every result is back, then lets the
  // pipeline settle.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    bit rdy;
    drain();
    cfg_chan.valid          <= 1'b1;
    cfg_chan.parallel_limit <= v;
    do begin
      @(negedge clk);
      rdy = cfg_chan.ready;
      @(posedge clk);
    end while (!rdy);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] small_val(input int span_bits);
    return $signed($urandom_range(0, (1 << (span_bits + 1)) - 1)) - (1 << span_bits);
  endfunction

  function automatic logic signed [31:0] edge_val();
    case ($urandom_range(0, 4))
      0: return SMAX;
      1: return SMIN;
      2: return '0;
      3: return ONE;
      default: return $urandom;
    endcase
  endfunction

  // Random plane sets: mostly solvable ones with modest values, plus parallel,
  // nearly parallel, diagonal, raw random and extreme-valued sets.
  function automatic plane_set_t random_planes();
    plane_set_t p;
    int         k;
    int         mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) p[i] = small_val((i % 4 == 3) ? 24 : 20);
    case (mode)
      5: begin
        k = $urandom_range(0, 3) - 1;
        for (int i = 0; i < 3; i++) p[8 + i] = p[i] * k;
      end
      6: for (int i = 0; i < 12; i++) p[i] = $urandom;
      7: for (int i = 0; i < 3; i++) p[4 + i] = p[i] + small_val(2);
      8: begin
        for (int i = 0; i < 12; i++) p[i] = '0;
        p[0] = small_val(20); p[5] = small_val(20); p[10] = small_val(20);
        p[3] = $urandom; p[7] = $urandom; p[11] = $urandom;
      end
      9: for (int i = 0; i < 12; i++) if ($urandom_range(0, 1)) p[i] = edge_val();
      default: ;
    endcase
    return p;
  endfunction

  function automatic plane_set_t diag_planes(input logic signed [31:0] a, b, c,
                                             input logic signed [31:0] da, db, dc);
    plane_set_t p;
    for (int i = 0; i < 12; i++) p[i] = '0;
    p[0] = a; p[5] = b; p[10] = c;
    p[3] = da; p[7] = db; p[11] = dc;
    return p;
  endfunction

  task automatic random_phase(input int count);
    repeat (count) send_planes(random_planes());
  endtask

  // Receiver side: random stalls, and one long hold-off once results flow.
  initial begin
    bit held;
    int g;
    held = 1'b0;
    out_chan.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!held && found_count + parallel_count >= 150) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_chan.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("three_plane_intersection_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    plane_set_t p;
    idle_cycles = 0;
    burst = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.parallel_limit = '0;
    for (int i = 0; i < 12; i++) p[i] = '0;
    {in_chan.first_normal_x, in_chan.first_normal_y, in_chan.first_normal_z,
     in_chan.first_dist, in_chan.second_normal_x, in_chan.second_normal_y,
     in_chan.second_normal_z, in_chan.second_dist, in_chan.third_normal_x,
     in_chan.third_normal_y, in_chan.third_normal_z, in_chan.third_dist} = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words with the reset limit: all zero, the point (1, 2, 3),
    // negative terms, saturation both ways and the field extremes.
    send_planes(p);
    send_planes(diag_planes(ONE, ONE, ONE, -ONE, -2 * ONE, -3 * ONE));
    send_planes(diag_planes(-ONE, 2 * ONE, ONE / 2, 5 * ONE, -ONE, ONE));
    send_planes(diag_planes(1 << 8, 1 << 8, 1 << 8, ONE, ONE, ONE));
    send_planes(diag_planes(1 << 11, 1 << 11, 1 << 11, SMIN, SMAX, 12345));
    send_planes(diag_planes(SMAX, SMAX, SMAX, SMIN, SMAX, 0));
    send_planes(diag_planes(SMIN, SMIN, SMIN, SMIN, SMAX, -1));
    send_planes(diag_planes(SMIN, SMAX, 1, SMAX, SMAX, SMAX));
    for (int i = 0; i < 12; i++) p[i] = SMAX;
    send_planes(p);
    for (int i = 0; i < 12; i++) p[i] = SMIN;
    send_planes(p);
    for (int i = 0; i < 12; i++) p[i] = (i % 2) ? SMIN : SMAX;
    send_planes(p);
    for (int i = 0; i < 12; i++) p[i] = -1;
    send_planes(p);
    random_phase(PHASE_WORDS);

    // Limit zero: only an exactly zero determinant is parallel.
    write_limit('0);
    send_planes(diag_planes(1, 1, 1, SMAX, SMIN, ONE));
    send_planes(diag_planes(0, ONE, ONE, ONE, ONE, ONE));
    burst = 1'b1;
    random_phase(PHASE_WORDS);
    burst = 1'b0;

    // Largest limit: nearly everything counts as parallel.
    write_limit({LIMIT_W{1'b1}});
    send_planes(diag_planes(SMAX, SMAX, SMAX, ONE, ONE, ONE));
    random_phase(PHASE_WORDS);

    write_limit($urandom_range(0, 1 << 20));
    random_phase(PHASE_WORDS);

    write_limit(ONE[LIMIT_W-1:0]);
    random_phase(PHASE_WORDS);

    drain();
    $display("Covered %0d solved and %0d parallel plane sets over five limit settings.",
             found_count, parallel_count);
    if (error_count == 0) begin
      $display("three_plane_intersection_tb: clean");
    end else begin
      $display("three_plane_intersection_tb: errors");
    end
    $finish;
  end
endmodule

>>> three_plane_intersection.f
rtl/tpi_pkg.sv
rtl/tpi_in_if.sv
rtl/tpi_out_if.sv
rtl/tpi_cfg_if.sv
rtl/tpi_div.sv
rtl/three_plane_intersection.sv
tb/sv/three_plane_intersection_chk.sv
tb/sv/three_plane_intersection_tb.sv
